// ===== rtl/lfsa_pkg.sv =====
// Package for the latest-free-slot allocator: sizes, controller states and
// the command/status bundles between controller and datapath.
// No dependencies.
`default_nettype none

package lfsa_pkg;

    localparam int SLOTS  = 1024;
    localparam int ADDR_W = $clog2(SLOTS);
    localparam int IDX_W  = $clog2(SLOTS + 1);
    localparam int NXT_W  = IDX_W + 1;
    localparam int CNT_W  = IDX_W;
    localparam int DL_W   = 16;
    localparam int SC_W   = 16;
    localparam int SLOT_W = 11;
    localparam int TOT_W  = 32;

    // largest power of two not above SLOTS: first step of the descent
    localparam logic [IDX_W-1:0] TOP_STEP = IDX_W'(1) << (IDX_W - 1);
    localparam logic [NXT_W-1:0] SLOTS_N  = NXT_W'(SLOTS);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(SLOTS - 1);

    localparam logic OP_REQUEST = 1'b0;
    localparam logic OP_CLEAR   = 1'b1;

    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_PF_CHK,
        S_PF_ACC,
        S_LOC_CHK,
        S_LOC_CMP,
        S_UPD_CHK,
        S_UPD_WR
    } state_t;

    typedef struct packed {
        logic start_req;   // capture a request
        logic start_clr;   // clear total, report, begin sweep
        logic sweep_wr;    // write one node of the initial tree
        logic pf_rd;       // prefix walk: read node idx
        logic pf_acc;      // prefix walk: accumulate, drop low bit
        logic loc_init;    // set up the descent
        logic loc_rd;      // descent: read node pos+step
        logic loc_skip;    // descent: pos+step beyond the tree
        logic loc_cmp;     // descent: compare and halve step
        logic upd_init;    // claim slot pos+1
        logic upd_rd;      // update walk: read node idx
        logic upd_wr;      // update walk: write back decremented count
        logic emit_drop;   // report a dropped request
        logic emit_grant;  // report a grant, add score
    } cmd_t;

    typedef struct packed {
        logic sweep_last;
        logic idx_zero;
        logic acc_zero;
        logic step_zero;
        logic nxt_ok;
        logic upd_done;
    } sts_t;

endpackage

`default_nettype wire

// ===== rtl/lfsa_ctrl.sv =====
// Controller state machine for the latest-free-slot allocator.
// Depends on lfsa_pkg; drives the datapath through cmd_t, watches sts_t.
`default_nettype none

module lfsa_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic          operation,
    input  wire lfsa_pkg::sts_t sts,
    output lfsa_pkg::cmd_t     cmd,
    output logic               busy
);
    import lfsa_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_SWEEP;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_SWEEP:
            begin
                if (sts.sweep_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                    state_next = (operation == OP_CLEAR) ? S_SWEEP : S_PF_CHK;
            end
            S_PF_CHK:
            begin
                if (!sts.idx_zero)
                    state_next = S_PF_ACC;
                else if (sts.acc_zero)
                    state_next = S_IDLE;
                else
                    state_next = S_LOC_CHK;
            end
            S_PF_ACC:
            begin
                state_next = S_PF_CHK;
            end
            S_LOC_CHK:
            begin
                if (sts.step_zero)
                    state_next = S_UPD_CHK;
                else if (sts.nxt_ok)
                    state_next = S_LOC_CMP;
            end
            S_LOC_CMP:
            begin
                state_next = S_LOC_CHK;
            end
            S_UPD_CHK:
            begin
                state_next = sts.upd_done ? S_IDLE : S_UPD_WR;
            end
            S_UPD_WR:
            begin
                state_next = S_UPD_CHK;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        case (state_reg)
            S_SWEEP:
            begin
                cmd.sweep_wr = 1'b1;
            end
            S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.start_clr = (operation == OP_CLEAR);
                    cmd.start_req = (operation == OP_REQUEST);
                end
            end
            S_PF_CHK:
            begin
                if (!sts.idx_zero)
                    cmd.pf_rd = 1'b1;
                else if (sts.acc_zero)
                    cmd.emit_drop = 1'b1;
                else
                    cmd.loc_init = 1'b1;
            end
            S_PF_ACC:
            begin
                cmd.pf_acc = 1'b1;
            end
            S_LOC_CHK:
            begin
                if (sts.step_zero)
                    cmd.upd_init = 1'b1;
                else if (sts.nxt_ok)
                    cmd.loc_rd = 1'b1;
                else
                    cmd.loc_skip = 1'b1;
            end
            S_LOC_CMP:
            begin
                cmd.loc_cmp = 1'b1;
            end
            S_UPD_CHK:
            begin
                if (sts.upd_done)
                    cmd.emit_grant = 1'b1;
                else
                    cmd.upd_rd = 1'b1;
            end
            S_UPD_WR:
            begin
                cmd.upd_wr = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/lfsa_dpath.sv =====
// Datapath for the latest-free-slot allocator: Fenwick tree memory of free
// counts, walk/descent registers, score total and result registers.
// Depends on lfsa_pkg; sequenced by lfsa_ctrl.
`default_nettype none

module lfsa_dpath (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire lfsa_pkg::cmd_t              cmd,
    input  wire logic [lfsa_pkg::DL_W-1:0]   deadline,
    input  wire logic [lfsa_pkg::SC_W-1:0]   score,
    output lfsa_pkg::sts_t                   sts,
    output logic                             done,
    output logic                             granted,
    output logic [lfsa_pkg::SLOT_W-1:0]      slot,
    output logic [lfsa_pkg::TOT_W-1:0]       total
);
    import lfsa_pkg::*;

    logic [CNT_W-1:0]  tree_mem [SLOTS];
    logic [CNT_W-1:0]  rd_reg;

    logic [ADDR_W-1:0] cnt_reg,   cnt_next;
    logic [NXT_W-1:0]  idx_reg,   idx_next;
    logic [CNT_W-1:0]  acc_reg,   acc_next;
    logic [IDX_W-1:0]  pos_reg,   pos_next;
    logic [IDX_W-1:0]  step_reg,  step_next;
    logic [CNT_W-1:0]  want_reg,  want_next;
    logic [SC_W-1:0]   score_reg, score_next;
    logic [TOT_W-1:0]  total_reg, total_next;
    logic              done_reg,  done_next;
    logic              granted_reg, granted_next;
    logic [SLOT_W-1:0] slot_reg,  slot_next;

    logic [NXT_W-1:0]  nxt;
    logic [NXT_W-1:0]  idx_low;
    logic [IDX_W-1:0]  sweep_idx;
    logic [NXT_W-1:0]  dl_clamped;
    logic [TOT_W:0]    total_sum;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [CNT_W-1:0]  wr_data;
    logic [IDX_W-1:0]  pos_inc;

    assign nxt       = NXT_W'(pos_reg) + NXT_W'(step_reg);
    assign idx_low   = idx_reg & (~idx_reg + NXT_W'(1));
    assign sweep_idx = IDX_W'(cnt_reg) + IDX_W'(1);
    assign pos_inc   = pos_reg + IDX_W'(1);
    assign total_sum = {1'b0, total_reg} + (TOT_W+1)'(score_reg);

    always_comb
    begin
        if ({1'b0, deadline} > (DL_W+1)'(SLOTS))
            dl_clamped = SLOTS_N;
        else
            dl_clamped = NXT_W'(deadline);
    end

    // one read port, one write port
    assign rd_en   = cmd.pf_rd | cmd.loc_rd | cmd.upd_rd;
    assign rd_addr = cmd.loc_rd ? ADDR_W'(nxt - NXT_W'(1)) : ADDR_W'(idx_reg - NXT_W'(1));
    assign wr_en   = cmd.sweep_wr | cmd.upd_wr;
    assign wr_addr = cmd.sweep_wr ? cnt_reg : ADDR_W'(idx_reg - NXT_W'(1));
    assign wr_data = cmd.sweep_wr ? CNT_W'(sweep_idx & (~sweep_idx + IDX_W'(1)))
                                  : rd_reg - CNT_W'(1);

    always_ff @(posedge clk)
    begin
        if (wr_en)
            tree_mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_reg <= tree_mem[rd_addr];
    end

    always_comb
    begin
        cnt_next     = cnt_reg;
        idx_next     = idx_reg;
        acc_next     = acc_reg;
        pos_next     = pos_reg;
        step_next    = step_reg;
        want_next    = want_reg;
        score_next   = score_reg;
        total_next   = total_reg;
        done_next    = 1'b0;
        granted_next = granted_reg;
        slot_next    = slot_reg;

        if (cmd.sweep_wr)
            cnt_next = cnt_reg + ADDR_W'(1);
        if (cmd.start_clr)
        begin
            cnt_next     = '0;
            total_next   = '0;
            done_next    = 1'b1;
            granted_next = 1'b0;
            slot_next    = '0;
        end
        if (cmd.start_req)
        begin
            idx_next   = dl_clamped;
            acc_next   = '0;
            score_next = score;
        end
        if (cmd.pf_acc)
        begin
            acc_next = acc_reg + rd_reg;
            idx_next = idx_reg & (idx_reg - NXT_W'(1));
        end
        if (cmd.loc_init)
        begin
            pos_next  = '0;
            step_next = TOP_STEP;
            want_next = acc_reg;
        end
        if (cmd.loc_skip)
            step_next = step_reg >> 1;
        if (cmd.loc_cmp)
        begin
            step_next = step_reg >> 1;
            if (rd_reg < want_reg)
            begin
                pos_next  = IDX_W'(nxt);
                want_next = want_reg - rd_reg;
            end
        end
        if (cmd.upd_init)
        begin
            idx_next  = NXT_W'(pos_inc);
            slot_next = SLOT_W'(pos_inc);
        end
        if (cmd.upd_wr)
            idx_next = idx_reg + idx_low;
        if (cmd.emit_drop)
        begin
            done_next    = 1'b1;
            granted_next = 1'b0;
            slot_next    = '0;
        end
        if (cmd.emit_grant)
        begin
            done_next    = 1'b1;
            granted_next = 1'b1;
            // saturate on carry out
            total_next   = total_sum[TOT_W] ? '1 : total_sum[TOT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            total_reg   <= '0;
            done_reg    <= 1'b0;
            granted_reg <= 1'b0;
            slot_reg    <= '0;
        end
        else
        begin
            cnt_reg     <= cnt_next;
            total_reg   <= total_next;
            done_reg    <= done_next;
            granted_reg <= granted_next;
            slot_reg    <= slot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        acc_reg   <= acc_next;
        pos_reg   <= pos_next;
        step_reg  <= step_next;
        want_reg  <= want_next;
        score_reg <= score_next;
    end

    assign sts.sweep_last = (cnt_reg == LAST_ADDR);
    assign sts.idx_zero   = (idx_reg == '0);
    assign sts.acc_zero   = (acc_reg == '0);
    assign sts.step_zero  = (step_reg == '0);
    assign sts.nxt_ok     = (nxt <= SLOTS_N);
    assign sts.upd_done   = (idx_reg > SLOTS_N);

    assign done    = done_reg;
    assign granted = granted_reg;
    assign slot    = slot_reg;
    assign total   = total_reg;

endmodule

`default_nettype wire

// ===== rtl/latest_free_slot_allocator.sv =====
// Latest-free-slot allocator: greedy unit-job scheduler over a Fenwick tree.
// Requests walk the prefix nodes, descend the tree (skipping steps beyond it) and
// walk the update nodes before the result; a clear reports as its sweep begins;
// one transaction at a time; tree reads and writes use one port each.
// Reset and clear: a sweep rebuilds every tree node, busy stays high.
// done pulses for one cycle with the result; it cannot be held off.
`default_nettype none

module latest_free_slot_allocator (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          operation,
    input  wire logic [lfsa_pkg::DL_W-1:0]     deadline,
    input  wire logic [lfsa_pkg::SC_W-1:0]     score,
    output logic                               done,
    output logic                               granted,
    output logic [lfsa_pkg::SLOT_W-1:0]        slot,
    output logic [lfsa_pkg::TOT_W-1:0]         total
);
    import lfsa_pkg::*;

    cmd_t cmd;
    sts_t sts;

    lfsa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (operation),
        .sts       (sts),
        .cmd       (cmd),
        .busy      (busy)
    );

    lfsa_dpath u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .deadline (deadline),
        .score    (score),
        .sts      (sts),
        .done     (done),
        .granted  (granted),
        .slot     (slot),
        .total    (total)
    );

endmodule

`default_nettype wire

// ===== dv/latest_free_slot_allocator_tb.sv =====
// Self-checking testbench for the latest-free-slot allocator: directed, full-fill
// and random-episode request streams against a free-slot map predictor.
// Depends on lfsa_pkg and latest_free_slot_allocator.
`timescale 1ns / 100ps

module latest_free_slot_allocator_tb;

    import lfsa_pkg::*;

    localparam int WATCHDOG_LIMIT = 6000;  // covers the reset/clear sweep, long gaps, latency
    localparam int DRAIN_CYCLES   = 200;
    localparam int ITEM_TARGET    = 1550;

    typedef struct packed {
        logic              granted;
        logic [SLOT_W-1:0] slot;
        logic [TOT_W-1:0]  total;
    } alloc_result_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic              operation;
    logic [DL_W-1:0]   deadline;
    logic [SC_W-1:0]   score;
    logic              done;
    logic              granted;
    logic [SLOT_W-1:0] slot;
    logic [TOT_W-1:0]  total;

    alloc_result_t    expected_allocs[$];
    bit               slot_taken [1:SLOTS];
    int               free_slots;
    logic [TOT_W-1:0] score_sum;
    int               fault_count;
    int               stall_cycles;
    int               items_sent;
    bit               gaps_enabled;

    always #5 clk = ~clk;

    latest_free_slot_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .operation (operation),
        .deadline  (deadline),
        .score     (score),
        .done      (done),
        .granted   (granted),
        .slot      (slot),
        .total     (total)
    );

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        fault_count++;
    endtask

    task automatic free_all_slots();
        foreach (slot_taken[i])
            slot_taken[i] = 1'b0;
        free_slots = SLOTS;
        score_sum  = '0;
    endtask

    // Frees all on clear; else claims latest free slot at or below clamped deadline.
    task automatic predict_alloc(input logic op, input logic [DL_W-1:0] dl,
                                 input logic [SC_W-1:0] sc);
        alloc_result_t r;
        int            limit;
        r = '0;
        if (op == OP_CLEAR) begin
            free_all_slots();
        end
        else begin
            limit = (int'(dl) > SLOTS) ? SLOTS : int'(dl);
            for (int s = limit; s >= 1 && !r.granted; s--) begin
                if (!slot_taken[s]) begin
                    slot_taken[s] = 1'b1;
                    free_slots--;
                    r.granted = 1'b1;
                    r.slot    = SLOT_W'(s);
                    if (score_sum > {TOT_W{1'b1}} - TOT_W'(sc))
                        score_sum = {TOT_W{1'b1}};
                    else
                        score_sum = score_sum + TOT_W'(sc);
                end
            end
        end
        r.total = score_sum;
        expected_allocs.push_back(r);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Entered just after a rising edge; returns at the edge that accepts the transaction.
    task automatic issue_command(input logic op, input logic [DL_W-1:0] dl,
                                 input logic [SC_W-1:0] sc);
        int gap;
        gap = gaps_enabled ? pick_gap() : 0;
        @(negedge clk);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start     <= 1'b1;
        operation <= op;
        deadline  <= dl;
        score     <= sc;
        do
            @(posedge clk);
        while (busy);
        items_sent++;
        predict_alloc(op, dl, sc);
    endtask

    task automatic test_directed();
        issue_command(OP_CLEAR, '0, '0);
        issue_command(OP_REQUEST, 16'd0, 16'hFFFF);      // deadline zero: dropped
        issue_command(OP_REQUEST, 16'd1, 16'hFFFF);
        issue_command(OP_REQUEST, 16'd1, 16'hFFF0);      // slot 1 taken: dropped
        issue_command(OP_REQUEST, 16'd3, 16'h8000);
        issue_command(OP_REQUEST, 16'd3, 16'h7FFF);
        issue_command(OP_REQUEST, 16'd3, 16'h1234);      // nothing left below 4
        issue_command(OP_REQUEST, 16'hFFFF, 16'h0000);   // clamped to the top slot
        issue_command(OP_REQUEST, 16'(SLOTS), 16'h00FF);
        issue_command(OP_REQUEST, 16'(SLOTS + 1), 16'h0F0F);
        issue_command(OP_REQUEST, 16'h8000, 16'h5555);
        issue_command(OP_REQUEST, 16'h7FFF, 16'hAAAA);
        issue_command(OP_REQUEST, 16'd2, 16'h0001);
        issue_command(OP_CLEAR, 16'hFFFF, 16'hFFFF);
        issue_command(OP_REQUEST, 16'd1, 16'h0002);
        issue_command(OP_REQUEST, 16'd700, 16'h0001);
    endtask

    // Claim every slot, then confirm a full tree drops everything.
    task automatic test_fill_all();
        int sc;
        int guard;
        sc    = 65535;
        guard = 0;
        issue_command(OP_CLEAR, 16'($urandom), 16'($urandom));
        while (free_slots != 0 && guard < 2000)
        begin
            if (guard % 64 == 0)
                gaps_enabled = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 4) == 0)
                issue_command(OP_REQUEST, 16'($urandom), 16'(sc));
            else
                issue_command(OP_REQUEST, 16'($urandom_range(SLOTS, 65535)), 16'(sc));
            sc = sc - $urandom_range(0, 120);
            if (sc < 0)
                sc = 0;
            guard++;
        end
        gaps_enabled = 1'b1;
        issue_command(OP_REQUEST, 16'hFFFF, 16'($urandom));
        issue_command(OP_REQUEST, 16'($urandom_range(1, SLOTS)), 16'($urandom));
    endtask

    // Episodes of descending-score requests over a deadline window, with noise.
    // The total cannot saturate: at most SLOTS grants of 16-bit scores between clears.
    task automatic test_random_episodes();
        int length;
        int window;
        int sc;
        int pick;
        logic [DL_W-1:0] dl;
        while (items_sent < ITEM_TARGET)
        begin
            if ($urandom_range(0, 3) == 0)
                issue_command(OP_CLEAR, 16'($urandom), 16'($urandom));
            gaps_enabled = ($urandom_range(0, 3) != 0);
            length = $urandom_range(8, 40);
            pick   = $urandom_range(0, 2);
            window = (pick == 0) ? $urandom_range(1, 64) :
                     (pick == 1) ? $urandom_range(1, SLOTS) : 65535;
            sc     = $urandom_range(0, 65535);
            for (int n = 0; n < length; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 2)
                begin
                    issue_command(OP_CLEAR, 16'($urandom), 16'($urandom));
                end
                else if (pick < 8)
                begin
                    issue_command(OP_REQUEST, 16'd0, 16'($urandom));
                end
                else if (pick < 18)
                begin
                    issue_command(OP_REQUEST, 16'($urandom), 16'($urandom));
                end
                else
                begin
                    dl = (window == 65535) ? 16'($urandom_range(SLOTS - 16, 65535))
                                           : 16'($urandom_range(1, window));
                    issue_command(OP_REQUEST, dl, 16'(sc));
                    sc = sc - $urandom_range(0, 3000);
                    if (sc < 0)
                        sc = 0;
                end
            end
        end
    endtask

    always @(posedge clk)
    begin
        alloc_result_t want;
        if (rst_n && done)
        begin
            if (expected_allocs.size() == 0)
            begin
                report_mismatch("result with no transaction outstanding");
            end
            else
            begin
                want = expected_allocs.pop_front();
                if (granted !== want.granted)
                    report_mismatch($sformatf("granted %b, want %b", granted, want.granted));
                if (slot !== want.slot)
                    report_mismatch($sformatf("slot %0d, want %0d", slot, want.slot));
                if (total !== want.total)
                    report_mismatch($sformatf("total %0d, want %0d", total, want.total));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        operation    = OP_REQUEST;
        deadline     = '0;
        score        = '0;
        fault_count  = 0;
        stall_cycles = 0;
        items_sent   = 0;
        gaps_enabled = 1'b1;
        free_all_slots();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_fill_all();
        test_random_episodes();

        @(negedge clk);
        start <= 1'b0;
        while (expected_allocs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fault_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
